FILE: src/accel_orientation_detector_core_macros.svh
// assertion macros for the orientation detector core
// used by files that carry concurrent checks; needs a clock and reset in scope
`ifndef ACCEL_ORIENTATION_DETECTOR_CORE_MACROS_SVH
`define ACCEL_ORIENTATION_DETECTOR_CORE_MACROS_SVH

// check that is masked while reset is high
`define AOD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check that also holds across reset
`define AOD_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: src/aod_pkg.sv
// shared types, codes and reset values for the orientation detector
// no dependencies
`default_nettype none

package aod_pkg;

   localparam int TIME_WIDTH_DEFAULT = 48;

   localparam int HYST_WIDTH = 15;
   localparam int DEBOUNCE_WIDTH = 24;
   localparam int MIN_WIDTH = 15;
   localparam int CSR_DATA_WIDTH = 24;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [HYST_WIDTH-1:0] HYSTERESIS_RESET = 15'd200;
   localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_RESET = 24'd500000;
   localparam logic [MIN_WIDTH-1:0] DOMINANT_MIN_RESET = 15'd400;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_HYSTERESIS = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DEBOUNCE = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DOMINANT_MIN = 2'd2;

   localparam logic [1:0] ROT_0 = 2'd0;
   localparam logic [1:0] ROT_90 = 2'd1;
   localparam logic [1:0] ROT_180 = 2'd2;
   localparam logic [1:0] ROT_270 = 2'd3;

   typedef enum logic [1:0] {
      AXIS_XPOS = 2'd0,
      AXIS_XNEG = 2'd1,
      AXIS_YPOS = 2'd2,
      AXIS_YNEG = 2'd3
   } axis_type;

   typedef struct packed {
      logic [HYST_WIDTH-1:0] hyst_margin_mg;
      logic [DEBOUNCE_WIDTH-1:0] debounce_time_us;
      logic [MIN_WIDTH-1:0] min_level_mg;
   } cfg_type;

   typedef struct packed {
      axis_type axis;
      logic [1:0] rotation_quarters;
      logic rotate_now;
   } result_type;

   function automatic logic [1:0] rotation_of(input axis_type a);
      logic [1:0] r;
      case (a)
         AXIS_XPOS: r = ROT_0;
         AXIS_XNEG: r = ROT_180;
         AXIS_YPOS: r = ROT_270;
         AXIS_YNEG: r = ROT_90;
         default: r = ROT_0;
      endcase
      return r;
   endfunction

   // reading along a signed axis, one bit wider than the sign-extended input
   function automatic logic signed [17:0] signed_reading(
      input axis_type a,
      input logic signed [16:0] x,
      input logic signed [16:0] y
   );
      logic signed [17:0] r;
      case (a)
         AXIS_XPOS: r = 18'(x);
         AXIS_XNEG: r = -18'(x);
         AXIS_YPOS: r = 18'(y);
         AXIS_YNEG: r = -18'(y);
         default: r = 18'(x);
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: src/aod_step.sv
// next-state and result logic for one sample of the orientation detector
// depends on aod_pkg
`default_nettype none

module aod_step #(
   parameter int TIME_WIDTH = aod_pkg::TIME_WIDTH_DEFAULT
) (
   input wire logic signed [15:0] accel_x,
   input wire logic signed [15:0] accel_y,
   input wire logic [TIME_WIDTH-1:0] time_us,
   input wire aod_pkg::cfg_type cfg,
   input wire aod_pkg::axis_type committed_axis,
   input wire aod_pkg::axis_type pending_axis,
   input wire logic [TIME_WIDTH-1:0] candidate_start,
   output aod_pkg::axis_type committed_axis_next,
   output aod_pkg::axis_type pending_axis_next,
   output logic [TIME_WIDTH-1:0] candidate_start_next,
   output aod_pkg::result_type result
);

   logic signed [16:0] x_ext;
   logic signed [16:0] y_ext;
   logic [16:0] abs_x;
   logic [16:0] abs_y;
   logic [16:0] mag;
   aod_pkg::axis_type dominant;
   aod_pkg::axis_type proposed;
   logic signed [17:0] committed_reading;
   logic signed [17:0] nxt_reading;
   logic signed [17:0] margin;
   logic [TIME_WIDTH-1:0] elapsed;
   logic commit;

   assign x_ext = 17'(accel_x);
   assign y_ext = 17'(accel_y);
   assign abs_x = x_ext[16] ? 17'(-x_ext) : 17'(x_ext);
   assign abs_y = y_ext[16] ? 17'(-y_ext) : 17'(y_ext);

   always_comb begin
      if (abs_x > abs_y) begin
         dominant = (x_ext > 17'sd0) ? aod_pkg::AXIS_XPOS : aod_pkg::AXIS_XNEG;
         mag = abs_x;
      end else begin
         dominant = (y_ext > 17'sd0) ? aod_pkg::AXIS_YPOS : aod_pkg::AXIS_YNEG;
         mag = abs_y;
      end
   end

   assign committed_reading = aod_pkg::signed_reading(committed_axis, x_ext, y_ext);
   assign nxt_reading = aod_pkg::signed_reading(dominant, x_ext, y_ext);
   assign margin = 18'(nxt_reading - committed_reading);
   assign elapsed = time_us - candidate_start;

   always_comb begin
      proposed = dominant;
      if (dominant != committed_axis &&
          margin < $signed({3'b000, cfg.hyst_margin_mg})) begin
         proposed = committed_axis;
      end
   end

   always_comb begin
      committed_axis_next = committed_axis;
      pending_axis_next = pending_axis;
      candidate_start_next = candidate_start;
      commit = 1'b0;
      if (mag >= {2'b00, cfg.min_level_mg}) begin
         if (proposed != pending_axis) begin
            pending_axis_next = proposed;
            candidate_start_next = time_us;
         end else if (pending_axis != committed_axis) begin
            if (elapsed >= TIME_WIDTH'(cfg.debounce_time_us)) begin
               committed_axis_next = pending_axis;
               commit = 1'b1;
            end
         end
      end
   end

   always_comb begin
      result.axis = committed_axis_next;
      result.rotation_quarters = aod_pkg::rotation_of(committed_axis_next);
      result.rotate_now = commit;
   end

endmodule

`default_nettype wire

FILE: src/accel_orientation_detector_core.sv
// top level of the accelerometer orientation detector
// depends on aod_pkg, aod_step and the assertion macro header
//
// channel   dir  handshake              contents
// req_      in   tvalid/tready/tdata    accel_x, accel_y, time_us
// rsp_      out  tvalid/tready/tdata/tuser axis, rotation_quarters; rotate_now
// csr_      in   we/index/wdata         hysteresis, debounce time, dominant minimum
//
// one sample per cycle while rsp_ does not stall; a taken sample reaches rsp_ after it
// passes the input register, then the decision logic into the result register
// orientation state updates as a sample moves into the result register
// reset is synchronous and active high; it restores the register defaults
// a stalled rsp_ holds its transaction while one more sample waits in the input
// register; req_tready drops only when both registers are full and rsp_ stalls
`default_nettype none
`include "accel_orientation_detector_core_macros.svh"

module accel_orientation_detector_core #(
   parameter int TIME_WIDTH = aod_pkg::TIME_WIDTH_DEFAULT,
   localparam int ReqDataWidth = ((32 + TIME_WIDTH + 7) / 8) * 8
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   output logic req_tready,
   // accel_x [15:0], accel_y [31:16], time_us [32+TIME_WIDTH-1:32], zero fill
   input wire logic [ReqDataWidth-1:0] req_tdata,
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   // axis [1:0], rotation_quarters [3:2], zero fill
   output logic [7:0] rsp_tdata,
   // rotate_now [0]
   output logic [0:0] rsp_tuser,
   input wire logic csr_we,
   input wire logic [aod_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input wire logic [aod_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);

   aod_pkg::cfg_type cfg_ff, cfg_in;

   logic in_valid_ff, in_valid_in;
   logic signed [15:0] in_x_ff, in_x_in;
   logic signed [15:0] in_y_ff, in_y_in;
   logic [TIME_WIDTH-1:0] in_time_ff, in_time_in;

   aod_pkg::axis_type current_ff, current_in;
   aod_pkg::axis_type candidate_ff, candidate_in;
   logic [TIME_WIDTH-1:0] start_ff, start_in;

   logic rsp_valid_ff, rsp_valid_in;
   aod_pkg::result_type rsp_ff, rsp_in;

   aod_pkg::axis_type step_current;
   aod_pkg::axis_type step_candidate;
   logic [TIME_WIDTH-1:0] step_start;
   aod_pkg::result_type step_result;

   logic req_fire;
   logic out_free;
   logic advance;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign advance = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_fire = req_tvalid && req_tready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            aod_pkg::REG_HYSTERESIS: cfg_in.hyst_margin_mg =
               csr_wdata[aod_pkg::HYST_WIDTH-1:0];
            aod_pkg::REG_DEBOUNCE: cfg_in.debounce_time_us =
               csr_wdata[aod_pkg::DEBOUNCE_WIDTH-1:0];
            aod_pkg::REG_DOMINANT_MIN: cfg_in.min_level_mg =
               csr_wdata[aod_pkg::MIN_WIDTH-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_x_in = in_x_ff;
      in_y_in = in_y_ff;
      in_time_in = in_time_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_x_in = req_tdata[15:0];
         in_y_in = req_tdata[31:16];
         in_time_in = req_tdata[32 +: TIME_WIDTH];
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   aod_step #(
      .TIME_WIDTH(TIME_WIDTH)
   ) u_step (
      .accel_x(in_x_ff),
      .accel_y(in_y_ff),
      .time_us(in_time_ff),
      .cfg(cfg_ff),
      .committed_axis(current_ff),
      .pending_axis(candidate_ff),
      .candidate_start(start_ff),
      .committed_axis_next(step_current),
      .pending_axis_next(step_candidate),
      .candidate_start_next(step_start),
      .result(step_result)
   );

   always_comb begin
      current_in = current_ff;
      candidate_in = candidate_ff;
      start_in = start_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         current_in = step_current;
         candidate_in = step_candidate;
         start_in = step_start;
         rsp_in = step_result;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hyst_margin_mg <= aod_pkg::HYSTERESIS_RESET;
         cfg_ff.debounce_time_us <= aod_pkg::DEBOUNCE_RESET;
         cfg_ff.min_level_mg <= aod_pkg::DOMINANT_MIN_RESET;
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         current_ff <= aod_pkg::AXIS_XPOS;
         candidate_ff <= aod_pkg::AXIS_XPOS;
         start_ff <= '1;
      end else begin
         cfg_ff <= cfg_in;
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         current_ff <= current_in;
         candidate_ff <= candidate_in;
         start_ff <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      in_x_ff <= in_x_in;
      in_y_ff <= in_y_in;
      in_time_ff <= in_time_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {4'b0000, rsp_ff.rotation_quarters, rsp_ff.axis};
   assign rsp_tuser = rsp_ff.rotate_now;

   `AOD_ASSERT(a_commit_changes_axis, advance && step_result.rotate_now |=> current_ff != $past(current_ff), "commit left the axis unchanged")
   `AOD_ASSERT(a_state_holds_without_transaction, !advance |=> $stable(current_ff) && $stable(candidate_ff) && $stable(start_ff), "orientation state moved without a transaction")
   `AOD_ASSERT(a_ready_only_drops_on_stall, !req_tready |-> in_valid_ff && rsp_valid_ff && !rsp_tready, "input stalled with room downstream")
   `AOD_ASSERT_RST(a_reset_state, reset |=> current_ff == aod_pkg::AXIS_XPOS && !rsp_tvalid && req_tready, "state not cleared by reset")

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// self-checking testbench for accel_orientation_detector_core
// drives directed and random accelerometer samples and checks each result against a given
// expectation or an in-file model of the axis choice, hysteresis and debounce; needs aod_pkg and the rtl
module tb;

   localparam int TW = aod_pkg::TIME_WIDTH_DEFAULT;
   localparam int REQ_W = ((32 + TW + 7) / 8) * 8;
   localparam logic [1:0] TURNS [4] = '{aod_pkg::ROT_0, aod_pkg::ROT_180,
                                        aod_pkg::ROT_270, aod_pkg::ROT_90};

   typedef enum logic {ROW_SAMPLE, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic known;
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic [TW-1:0] stamp;
      logic [aod_pkg::CSR_INDEX_WIDTH-1:0] reg_idx;
      logic [aod_pkg::CSR_DATA_WIDTH-1:0] reg_val;
      aod_pkg::result_type want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // accel_x [15:0], accel_y [31:16], time_us [79:32]
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // axis [1:0], rotation_quarters [3:2], zero fill
   logic [7:0] rsp_tdata;
   // rotate_now [0]
   logic [0:0] rsp_tuser;
   logic csr_we = 1'b0;
   logic [aod_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [aod_pkg::CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   logic [aod_pkg::HYST_WIDTH-1:0] hyst_mg = aod_pkg::HYSTERESIS_RESET;
   logic [aod_pkg::DEBOUNCE_WIDTH-1:0] hold_us = aod_pkg::DEBOUNCE_RESET;
   logic [aod_pkg::MIN_WIDTH-1:0] floor_mg = aod_pkg::DOMINANT_MIN_RESET;
   aod_pkg::axis_type held_axis = aod_pkg::AXIS_XPOS;
   aod_pkg::axis_type pending_axis = aod_pkg::AXIS_XPOS;
   logic [TW-1:0] pending_since = '1;

   aod_pkg::result_type orientations_due[$];
   plan_row_type plan[$];
   logic [TW-1:0] stamp = '0;
   int send_idle_pct = 33;
   int recv_idle_pct = 68;
   int hold_off = 0;
   int errors = 0;
   int samples_sent = 0;
   int results_seen = 0;
   int commits_seen = 0;
   int csr_writes = 0;

   accel_orientation_detector_core #(.TIME_WIDTH(TW)) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int reading_along(aod_pkg::axis_type a, int x, int y);
      case (a)
         aod_pkg::AXIS_XPOS: return x;
         aod_pkg::AXIS_XNEG: return -x;
         aod_pkg::AXIS_YPOS: return y;
         default: return -y;
      endcase
   endfunction

   function automatic aod_pkg::result_type advance_orientation(logic signed [15:0] sx,
                                                               logic signed [15:0] sy,
                                                               logic [TW-1:0] now);
      int x, y, mx, my, mag;
      aod_pkg::axis_type want_axis;
      logic [TW-1:0] waited;
      aod_pkg::result_type r;
      x = int'(sx);
      y = int'(sy);
      mx = (x < 0) ? -x : x;
      my = (y < 0) ? -y : y;
      if (mx > my) begin
         mag = mx;
         if (x > 0) want_axis = aod_pkg::AXIS_XPOS;
         else want_axis = aod_pkg::AXIS_XNEG;
      end else begin
         mag = my;
         if (y > 0) want_axis = aod_pkg::AXIS_YPOS;
         else want_axis = aod_pkg::AXIS_YNEG;
      end
      r.rotate_now = 1'b0;
      if (mag >= int'(floor_mg)) begin
         if (want_axis != held_axis &&
             reading_along(want_axis, x, y) - reading_along(held_axis, x, y) < int'(hyst_mg))
            want_axis = held_axis;
         if (want_axis != pending_axis) begin
            pending_axis = want_axis;
            pending_since = now;
         end else if (pending_axis != held_axis) begin
            waited = now - pending_since;
            if (waited >= TW'(hold_us)) begin
               held_axis = pending_axis;
               r.rotate_now = 1'b1;
            end
         end
      end
      r.axis = held_axis;
      r.rotation_quarters = TURNS[held_axis];
      return r;
   endfunction

   function automatic void plan_sample(int x, int y, logic [TW-1:0] t, bit known = 1'b0,
                                       aod_pkg::axis_type a = aod_pkg::AXIS_XPOS,
                                       logic [1:0] rot = aod_pkg::ROT_0,
                                       logic commit = 1'b0);
      plan_row_type r;
      r = '0;
      r.kind = ROW_SAMPLE;
      r.known = known;
      r.ax = 16'(x);
      r.ay = 16'(y);
      r.stamp = t;
      r.want.axis = a;
      r.want.rotation_quarters = rot;
      r.want.rotate_now = commit;
      plan.push_back(r);
   endfunction

   function automatic void plan_csr(logic [aod_pkg::CSR_INDEX_WIDTH-1:0] idx,
                                    logic [aod_pkg::CSR_DATA_WIDTH-1:0] val);
      plan_row_type r;
      r = '0;
      r.kind = ROW_CSR;
      r.reg_idx = idx;
      r.reg_val = val;
      plan.push_back(r);
   endfunction

   task automatic push_sample(logic signed [15:0] x, logic signed [15:0] y,
                              logic [TW-1:0] t, logic known, aod_pkg::result_type want);
      aod_pkg::result_type got;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_W'({t, y, x});
      do @(posedge clock); while (!req_tready);
      got = advance_orientation(x, y, t);
      orientations_due.push_back(known ? want : got);
      samples_sent++;
   endtask

   task automatic stop_req();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic write_csr(logic [aod_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            logic [aod_pkg::CSR_DATA_WIDTH-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         aod_pkg::REG_HYSTERESIS: hyst_mg = val[aod_pkg::HYST_WIDTH-1:0];
         aod_pkg::REG_DEBOUNCE: hold_us = val[aod_pkg::DEBOUNCE_WIDTH-1:0];
         aod_pkg::REG_DOMINANT_MIN: floor_mg = val[aod_pkg::MIN_WIDTH-1:0];
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // a run of samples leaning on one signed axis, spaced a third to a half of the debounce time apart
   task automatic run_episode();
      int steps, lead, side;
      bit on_x, flip;
      steps = $urandom_range(2, 6);
      on_x = 1'($urandom_range(1));
      flip = 1'($urandom_range(1));
      repeat (steps) begin
         lead = $urandom_range(32767, floor_mg);
         side = $urandom_range(lead);
         if ($urandom_range(1) == 1) side = -side;
         if (flip) lead = -lead;
         stamp = stamp + TW'($urandom_range(hold_us / 3, hold_us / 2 + 2));
         if (on_x) push_sample(16'(lead), 16'(side), stamp, 1'b0, '0);
         else push_sample(16'(side), 16'(lead), stamp, 1'b0, '0);
      end
   endtask

   initial begin
      int stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            stall = hold_off;
            hold_off = 0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      aod_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (rsp_tuser[0]) commits_seen++;
         if (orientations_due.size() == 0) begin
            $display("%0t: result with nothing pending: axis %0d rotation %0d rotate_now %0d",
                     $time, rsp_tdata[1:0], rsp_tdata[3:2], rsp_tuser[0]);
            errors++;
         end else begin
            want = orientations_due.pop_front();
            if (rsp_tdata[1:0] !== 2'(want.axis)) begin
               $display("%0t: axis expected %0d actual %0d", $time, want.axis, rsp_tdata[1:0]);
               errors++;
            end
            if (rsp_tdata[3:2] !== want.rotation_quarters) begin
               $display("%0t: rotation_quarters expected %0d actual %0d", $time,
                        want.rotation_quarters, rsp_tdata[3:2]);
               errors++;
            end
            if (rsp_tuser[0] !== want.rotate_now) begin
               $display("%0t: rotate_now expected %0d actual %0d", $time,
                        want.rotate_now, rsp_tuser[0]);
               errors++;
            end
         end
      end
   end

   initial begin
      int target;
      logic [aod_pkg::CSR_DATA_WIDTH-1:0] h, d, m;

      // defaults after reset: 200 mg margin, 500 ms hold, 400 mg floor
      plan_sample(0, 0, 0, 1'b1, aod_pkg::AXIS_XPOS, aod_pkg::ROT_0, 1'b0);
      plan_sample(32767, 0, 10, 1'b1, aod_pkg::AXIS_XPOS, aod_pkg::ROT_0, 1'b0);
      plan_sample(-32767, 5, 20, 1'b1, aod_pkg::AXIS_XPOS, aod_pkg::ROT_0, 1'b0);
      plan_sample(-32767, 0, 500019);
      plan_sample(-32767, 0, 500020);
      plan_sample(0, -32768, 600000);
      plan_sample(0, -32768, 1100000);
      plan_sample(500, 500, 1200000);
      plan_sample(300, -300, 1300000);
      plan_sample(400, 399, 1700000);
      plan_sample(-450, -300, 1800000);
      // zero margin, zero hold, zero floor: a tie at zero counts as -y
      plan_csr(aod_pkg::REG_HYSTERESIS, 0);
      plan_csr(aod_pkg::REG_DEBOUNCE, 0);
      plan_csr(aod_pkg::REG_DOMINANT_MIN, 0);
      plan_sample(1000, 0, 5);
      plan_sample(1000, 0, 5);
      plan_sample(0, 0, 6);
      plan_sample(0, 0, 6);
      plan_csr(aod_pkg::REG_HYSTERESIS, 32767);
      plan_csr(aod_pkg::REG_DEBOUNCE, 24'hFF_FFFF);
      plan_csr(aod_pkg::REG_DOMINANT_MIN, 32767);
      plan_sample(32767, 0, 100);
      plan_sample(32766, 0, 200);
      plan_sample(32767, 0, 100 + 16777214);
      plan_sample(32767, 0, 100 + 16777215);
      // timestamp wrap and a timestamp going backwards
      plan_csr(aod_pkg::REG_HYSTERESIS, aod_pkg::CSR_DATA_WIDTH'(aod_pkg::HYSTERESIS_RESET));
      plan_csr(aod_pkg::REG_DEBOUNCE, aod_pkg::DEBOUNCE_RESET);
      plan_csr(aod_pkg::REG_DOMINANT_MIN, aod_pkg::CSR_DATA_WIDTH'(aod_pkg::DOMINANT_MIN_RESET));
      plan_sample(0, 32767, 48'hFFFF_FFFF_FFF0);
      plan_sample(0, 32767, 48'h10);
      plan_sample(0, 32767, 48'hFFFF_FFFF_FF00);
      plan_sample(-32768, 0, 48'hFFFF_FFFF_FFFF);
      plan_sample(32767, -32767, 48'h0);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            stop_req();
            wait (orientations_due.size() == 0);
            write_csr(plan[i].reg_idx, plan[i].reg_val);
         end else begin
            push_sample(plan[i].ax, plan[i].ay, plan[i].stamp, plan[i].known, plan[i].want);
         end
      end

      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 33 : (mode == 1) ? 68 : 0;
         recv_idle_pct = (mode == 0) ? 68 : (mode == 1) ? 33 : 0;
         for (int phase = 0; phase < 4; phase++) begin
            stop_req();
            wait (orientations_due.size() == 0);
            case (phase)
               0: begin
                  h = 24'($urandom_range(400));
                  d = 24'($urandom_range(64));
                  m = 24'($urandom_range(600));
               end
               1: begin
                  h = 24'($urandom_range(2000));
                  d = 24'($urandom_range(600000, 1000));
                  m = 24'($urandom_range(3000));
               end
               2: begin
                  h = $urandom_range(1) ? 24'd32767 : 24'd0;
                  d = $urandom_range(1) ? 24'hFF_FFFF : 24'd0;
                  m = $urandom_range(1) ? 24'd32767 : 24'd0;
               end
               default: begin
                  h = 24'($urandom_range(32767));
                  d = 24'($urandom_range(24'hFF_FFFF));
                  m = 24'($urandom_range(32767));
               end
            endcase
            write_csr(aod_pkg::REG_HYSTERESIS, h);
            write_csr(aod_pkg::REG_DEBOUNCE, d);
            write_csr(aod_pkg::REG_DOMINANT_MIN, m);
            // long receiver stall so the core backs up into the request side
            if (phase == 1) hold_off = 150;
            target = samples_sent + 108;
            while (samples_sent < target) begin
               if ($urandom_range(99) < 75) begin
                  run_episode();
               end else begin
                  case ($urandom_range(3))
                     0: stamp = {16'($urandom), $urandom};
                     1: stamp = stamp - TW'($urandom_range(5000));
                     default: stamp = stamp + TW'($urandom_range(hold_us));
                  endcase
                  push_sample(16'($urandom), 16'($urandom), stamp, 1'b0, '0);
               end
            end
         end
      end

      stop_req();
      wait (orientations_due.size() == 0);
      repeat (10) @(posedge clock);
      $display("sent %0d samples over %0d register writes; checked %0d results, %0d commits",
               samples_sent, csr_writes, results_seen, commits_seen);
      if (errors == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("timeout with %0d results outstanding", orientations_due.size());
      $display("tb failed");
      $finish;
   end

endmodule
